@@ src/vehicle_safety_fault_supervisor_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef VEHICLE_SAFETY_FAULT_SUPERVISOR_CORE_MACROS_SVH
`define VEHICLE_SAFETY_FAULT_SUPERVISOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// check with reset masking
`define VSFS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds during reset
`define VSFS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VSFS_ASSERT(lbl, clk, rst, prop, msg)
`define VSFS_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

@@ src/vsfs_pkg.sv @@
// ----------------------------------------------------------------------------
// vsfs_pkg
// Shared types, codes and helpers of the fault supervisor.
// ----------------------------------------------------------------------------
package vsfs_pkg;

  localparam logic [2:0] OP_UPDATE = 3'd0;
  localparam logic [2:0] OP_IMU    = 3'd1;
  localparam logic [2:0] OP_KICK   = 3'd2;
  localparam logic [2:0] OP_START  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam int F_ESTOP  = 0;
  localparam int F_ADC    = 1;
  localparam int F_LOWBAT = 2;
  localparam int F_IMU    = 3;
  localparam int F_COMM   = 4;
  localparam int F_ENC    = 5;

  localparam logic [2:0] REG_BATTERY_LOW_MV       = 3'd0;
  localparam logic [2:0] REG_BATTERY_RECOVER_MV   = 3'd1;
  localparam logic [2:0] REG_LOW_BATTERY_DELAY_MS = 3'd2;
  localparam logic [2:0] REG_IMU_TIMEOUT_MS       = 3'd3;
  localparam logic [2:0] REG_COMM_TIMEOUT_MS      = 3'd4;
  localparam logic [2:0] REG_ENCODER_TEST_EFFORT  = 3'd5;
  localparam logic [2:0] REG_ENCODER_MIN_RATE     = 3'd6;
  localparam logic [2:0] REG_ENCODER_DELAY_MS     = 3'd7;

  typedef struct packed {
    logic [15:0] effort_min;
    logic [23:0] rate_min;
    logic [15:0] delay_ms;
  } lane_cfg_t;

  typedef struct packed {
    logic        update;
    logic        active;
    logic [31:0] now_ms;
  } lane_ctl_t;

  typedef struct packed {
    logic [5:0]  fault_mask;
    logic        stop_drive;
    logic        request_granted;
    logic [31:0] command_age_ms;
    logic        estop_seen;
    logic        imu_ok;
  } result_t;

  // two's complement magnitude; the most negative value maps to 2^(w-1)
  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? (16'h0 - v) : v;
  endfunction

  function automatic logic [23:0] abs24(input logic signed [23:0] v);
    abs24 = v[23] ? (24'h0 - v) : v;
  endfunction

endpackage

@@ src/vsfs_wheel_lane.sv @@
// ----------------------------------------------------------------------------
// vsfs_wheel_lane
// Stall timer for one wheel: high effort with low encoder rate over a delay.
// ----------------------------------------------------------------------------
module vsfs_wheel_lane (
  input  logic                    clk,
  input  logic                    rst,
  input  vsfs_pkg::lane_ctl_t     ctl,
  input  vsfs_pkg::lane_cfg_t     cfg,
  input  logic signed [15:0]      effort,
  input  logic signed [23:0]      rate,
  output logic                    fault
);

  logic        timing;
  logic [31:0] since;
  logic        stalled;
  logic [31:0] age;

  assign stalled = (vsfs_pkg::abs16(effort) >= cfg.effort_min) &&
                   (vsfs_pkg::abs24(rate) < cfg.rate_min);
  assign age     = ctl.now_ms - since;
  assign fault   = ctl.active && stalled && timing && (age >= {16'h0, cfg.delay_ms});

  always_ff @(posedge clk) begin
    if (rst) begin
      timing <= 1'b0;
      since  <= 32'h0;
    end else if (ctl.update) begin
      if (ctl.active && stalled) begin
        if (!timing) begin
          timing <= 1'b1;
          since  <= ctl.now_ms;
        end
      end else begin
        timing <= 1'b0;
      end
    end
  end

endmodule

@@ src/vsfs_out_buf.sv @@
// ----------------------------------------------------------------------------
// vsfs_out_buf
// Output register with a skid entry so a new item lands while one waits.
// ----------------------------------------------------------------------------
`include "vehicle_safety_fault_supervisor_core_macros.svh"

module vsfs_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vsfs_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output vsfs_pkg::result_t out_data
);

  logic              skid_valid;
  vsfs_pkg::result_t skid_data;
  logic              take;
  logic              load_out;
  logic              load_skid;

  assign full      = skid_valid;
  assign take      = out_valid && !out_stall;
  assign load_out  = push && (!out_valid || take);
  assign load_skid = push && out_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take && skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (load_out) begin
        out_valid <= 1'b1;
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      out_data <= skid_data;
    end else if (load_out) begin
      out_data <= push_data;
    end
    if (load_skid) begin
      skid_data <= push_data;
    end
  end

  `VSFS_ASSERT(a_skid_needs_out, clk, rst, skid_valid |-> out_valid, "skid full, out empty")
  `VSFS_ASSERT(a_push_to_skid, clk, rst, (push && out_valid && out_stall) |=> skid_valid, "push lost")
  `VSFS_ASSERT(a_skid_drains, clk, rst, (skid_valid && !out_stall) |=> (out_valid && !skid_valid), "skid not drained")

endmodule

@@ src/vehicle_safety_fault_supervisor_core.sv @@
// ----------------------------------------------------------------------------
// vehicle_safety_fault_supervisor_core
// Drive fault supervisor: latches faults from timestamped events.
//
//  channel  dir  handshake             payload
//  in       in   in_valid / in_stall   opcode, now_ms, sensors, efforts, rates
//  out      out  out_valid / out_stall fault_mask .. imu_ok
//  cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each result is registered in the output buffer on accept.
// All state, including the per-wheel stall lanes, updates in the accept cycle.
// A two-entry output buffer (register plus skid) keeps in_stall low until two
// results wait; in_stall is the skid occupancy. cfg_ready is always high.
// Reset (synchronous) loads register defaults and clears state; the battery sample time is preset to -PERIOD.
// ----------------------------------------------------------------------------
`include "vehicle_safety_fault_supervisor_core_macros.svh"

module vehicle_safety_fault_supervisor_core #(
  parameter int          WHEEL_COUNT              = 4,
  parameter int unsigned BATTERY_SAMPLE_PERIOD_MS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic [31:0]        now_ms,
  input  logic               estop_pressed,
  input  logic [15:0]        battery_mv,
  input  logic               adc_sample_ok,
  input  logic [1:0]         drive_status,
  input  logic signed [15:0] left_effort,
  input  logic signed [15:0] right_effort,
  input  logic signed [23:0] left_front_rate,
  input  logic signed [23:0] left_rear_rate,
  input  logic signed [23:0] right_front_rate,
  input  logic signed [23:0] right_rear_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         fault_mask,
  output logic               stop_drive,
  output logic               request_granted,
  output logic [31:0]        command_age_ms,
  output logic               estop_seen,
  output logic               imu_ok,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam logic [31:0] PERIOD     = 32'(BATTERY_SAMPLE_PERIOD_MS);
  localparam logic [31:0] BATT_RESET = 32'h0 - PERIOD;

  // configuration
  logic [15:0] battery_low_mv, battery_recover_mv, low_battery_delay_ms;
  logic [15:0] imu_timeout_ms, comm_timeout_ms, encoder_test_effort, encoder_delay_ms;
  logic [23:0] encoder_min_rate;

  // state
  logic [5:0]  latched_faults;
  logic [31:0] last_command_time, last_imu_time, last_battery_sample_time;
  logic [31:0] low_battery_since, refresh_time;
  logic        low_battery_timing, imu_healthy_flag, estop_flag, adc_healthy_flag;

  logic [5:0]  latched_faults_next;
  logic [31:0] last_command_time_next, last_imu_time_next, last_battery_sample_time_next;
  logic [31:0] low_battery_since_next, refresh_time_next;
  logic        low_battery_timing_next, imu_healthy_flag_next;
  logic        estop_flag_next, adc_healthy_flag_next;

  logic              accept;
  logic              is_update, is_start, is_clear, do_refresh;
  logic              running, closed;
  logic              sample_due, adc_now, batt_low, lowbat_hit, imu_bad, comm_hit;
  logic              start_ok, clear_ok, enc_hit;
  logic [15:0]       need_mv;
  logic [5:0]        base_faults, refresh_faults, update_faults;
  logic              stop_res, grant_res;
  logic [WHEEL_COUNT-1:0] lane_fault;
  logic signed [23:0] rates [4];
  vsfs_pkg::lane_cfg_t lane_cfg;
  vsfs_pkg::lane_ctl_t lane_ctl;
  vsfs_pkg::result_t   result, out_data;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign running   = drive_status[0];
  assign closed    = drive_status[1];
  assign is_update = (opcode == vsfs_pkg::OP_UPDATE);
  assign is_start  = (opcode == vsfs_pkg::OP_START);
  assign is_clear  = (opcode == vsfs_pkg::OP_CLEAR);
  assign do_refresh = is_update || is_start || is_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_low_mv       <= 16'd6600;
      battery_recover_mv   <= 16'd7000;
      low_battery_delay_ms <= 16'd1000;
      imu_timeout_ms       <= 16'd200;
      comm_timeout_ms      <= 16'd500;
      encoder_test_effort  <= 16'd300;
      encoder_min_rate     <= 24'd5;
      encoder_delay_ms     <= 16'd500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vsfs_pkg::REG_BATTERY_LOW_MV:       battery_low_mv       <= cfg_data[15:0];
        vsfs_pkg::REG_BATTERY_RECOVER_MV:   battery_recover_mv   <= cfg_data[15:0];
        vsfs_pkg::REG_LOW_BATTERY_DELAY_MS: low_battery_delay_ms <= cfg_data[15:0];
        vsfs_pkg::REG_IMU_TIMEOUT_MS:       imu_timeout_ms       <= cfg_data[15:0];
        vsfs_pkg::REG_COMM_TIMEOUT_MS:      comm_timeout_ms      <= cfg_data[15:0];
        vsfs_pkg::REG_ENCODER_TEST_EFFORT:  encoder_test_effort  <= cfg_data[15:0];
        vsfs_pkg::REG_ENCODER_MIN_RATE:     encoder_min_rate     <= cfg_data;
        vsfs_pkg::REG_ENCODER_DELAY_MS:     encoder_delay_ms     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // wheel lanes
  assign rates[0] = left_front_rate;
  assign rates[1] = left_rear_rate;
  assign rates[2] = right_front_rate;
  assign rates[3] = right_rear_rate;

  assign lane_cfg.effort_min = encoder_test_effort;
  assign lane_cfg.rate_min   = encoder_min_rate;
  assign lane_cfg.delay_ms   = encoder_delay_ms;
  assign lane_ctl.update     = accept && is_update;
  assign lane_ctl.active     = running && closed;
  assign lane_ctl.now_ms     = now_ms;

  for (genvar i = 0; i < WHEEL_COUNT; i++) begin : g_lane
    localparam int W = i % 4;
    vsfs_wheel_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (lane_ctl),
      .cfg    (lane_cfg),
      .effort ((W < 2) ? left_effort : right_effort),
      .rate   (rates[W]),
      .fault  (lane_fault[i])
    );
  end

  // merge
  assign enc_hit = |lane_fault;

  // input refresh
  assign sample_due = (now_ms - last_battery_sample_time) >= PERIOD;
  assign adc_now    = sample_due ? adc_sample_ok : adc_healthy_flag;
  assign batt_low   = (battery_mv != 16'h0) && (battery_mv < battery_low_mv);
  assign lowbat_hit = batt_low && low_battery_timing &&
                      ((now_ms - low_battery_since) >= {16'h0, low_battery_delay_ms});
  assign imu_bad    = !imu_healthy_flag ||
                      ((now_ms - last_imu_time) > {16'h0, imu_timeout_ms});
  assign comm_hit   = running &&
                      ((now_ms - last_command_time) > {16'h0, comm_timeout_ms});

  always_comb begin
    base_faults = latched_faults;
    if (is_start) base_faults[vsfs_pkg::F_COMM] = 1'b0;
    refresh_faults = base_faults;
    if (estop_pressed) refresh_faults[vsfs_pkg::F_ESTOP] = 1'b1;
    if (sample_due && !adc_sample_ok) refresh_faults[vsfs_pkg::F_ADC] = 1'b1;
    if (lowbat_hit) refresh_faults[vsfs_pkg::F_LOWBAT] = 1'b1;
    if (imu_bad) refresh_faults[vsfs_pkg::F_IMU] = 1'b1;
    update_faults = refresh_faults;
    if (comm_hit) update_faults[vsfs_pkg::F_COMM] = 1'b1;
    if (enc_hit) update_faults[vsfs_pkg::F_ENC] = 1'b1;
  end

  assign need_mv  = refresh_faults[vsfs_pkg::F_LOWBAT] ? battery_recover_mv : battery_low_mv;
  assign start_ok = !(estop_pressed || !adc_now || (battery_mv < battery_low_mv) || imu_bad) &&
                    (refresh_faults == 6'h0);
  assign clear_ok = !(estop_pressed || (battery_mv < need_mv) || !adc_now || imu_bad);

  always_comb begin
    latched_faults_next           = latched_faults;
    last_command_time_next        = last_command_time;
    last_imu_time_next            = last_imu_time;
    last_battery_sample_time_next = last_battery_sample_time;
    low_battery_since_next        = low_battery_since;
    low_battery_timing_next       = low_battery_timing;
    imu_healthy_flag_next         = imu_healthy_flag;
    estop_flag_next               = estop_flag;
    adc_healthy_flag_next         = adc_healthy_flag;
    refresh_time_next             = refresh_time;
    stop_res                      = 1'b0;
    grant_res                     = 1'b0;
    if (do_refresh) begin
      refresh_time_next     = now_ms;
      estop_flag_next       = estop_pressed;
      adc_healthy_flag_next = adc_now;
      if (sample_due) last_battery_sample_time_next = now_ms;
      low_battery_timing_next = batt_low;
      if (batt_low && !low_battery_timing) low_battery_since_next = now_ms;
      latched_faults_next = refresh_faults;
    end
    case (opcode)
      vsfs_pkg::OP_UPDATE: begin
        latched_faults_next = update_faults;
        stop_res            = (update_faults != 6'h0) && running;
      end
      vsfs_pkg::OP_IMU: begin
        last_imu_time_next    = now_ms;
        imu_healthy_flag_next = 1'b1;
      end
      vsfs_pkg::OP_KICK: begin
        last_command_time_next = now_ms;
      end
      vsfs_pkg::OP_START: begin
        last_command_time_next = now_ms;
        grant_res              = start_ok;
      end
      vsfs_pkg::OP_CLEAR: begin
        if (clear_ok) begin
          latched_faults_next     = 6'h0;
          low_battery_timing_next = 1'b0;
          last_command_time_next  = now_ms;
          grant_res               = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_faults           <= 6'h0;
      last_command_time        <= 32'h0;
      last_imu_time            <= 32'h0;
      last_battery_sample_time <= BATT_RESET;
      low_battery_since        <= 32'h0;
      low_battery_timing       <= 1'b0;
      imu_healthy_flag         <= 1'b0;
      estop_flag               <= 1'b0;
      adc_healthy_flag         <= 1'b0;
      refresh_time             <= 32'h0;
    end else if (accept) begin
      latched_faults           <= latched_faults_next;
      last_command_time        <= last_command_time_next;
      last_imu_time            <= last_imu_time_next;
      last_battery_sample_time <= last_battery_sample_time_next;
      low_battery_since        <= low_battery_since_next;
      low_battery_timing       <= low_battery_timing_next;
      imu_healthy_flag         <= imu_healthy_flag_next;
      estop_flag               <= estop_flag_next;
      adc_healthy_flag         <= adc_healthy_flag_next;
      refresh_time             <= refresh_time_next;
    end
  end

  assign result.fault_mask      = latched_faults_next;
  assign result.stop_drive      = stop_res;
  assign result.request_granted = grant_res;
  assign result.command_age_ms  = refresh_time_next - last_command_time_next;
  assign result.estop_seen      = estop_flag_next;
  assign result.imu_ok          = imu_healthy_flag_next;

  vsfs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign fault_mask      = out_data.fault_mask;
  assign stop_drive      = out_data.stop_drive;
  assign request_granted = out_data.request_granted;
  assign command_age_ms  = out_data.command_age_ms;
  assign estop_seen      = out_data.estop_seen;
  assign imu_ok          = out_data.imu_ok;

  `VSFS_ASSERT(a_stop_grant_excl, clk, rst, out_valid |-> !(stop_drive && request_granted), "stop and grant together")
  `VSFS_ASSERT(a_stop_has_fault, clk, rst, (out_valid && stop_drive) |-> (fault_mask != 6'h0), "stop without fault")
  `VSFS_ASSERT(a_grant_clean, clk, rst, (out_valid && request_granted) |-> (fault_mask == 6'h0), "grant with faults")

endmodule
